// File: rtl/core/ale_pkg.sv
// Shared types, constants and the channel order table of the LED bit encoder.
// No dependencies; used by every module in rtl/core.
package ale_pkg;

    localparam int NUM_LANES = 4;

    localparam logic [7:0]  FAST_HIGH_ONE  = 8'd62;
    localparam logic [7:0]  FAST_HIGH_ZERO = 8'd28;
    localparam logic [13:0] FAST_LOW       = 14'd68;
    localparam logic [7:0]  SLOW_HIGH_ONE  = 8'd125;
    localparam logic [7:0]  SLOW_HIGH_ZERO = 8'd55;
    localparam logic [13:0] SLOW_LOW       = 14'd150;
    localparam logic [13:0] LATCH_LEN      = 14'd7680;
    localparam logic [7:0]  FULL_SCALE     = 8'd255;

    localparam logic [4:0]  BITS_THREE = 5'd23;
    localparam logic [4:0]  BITS_FOUR  = 5'd31;

    typedef enum logic [1:0] {
        REG_ORDER_CODE    = 2'd0,
        REG_FOUR_CHANNELS = 2'd1,
        REG_SLOW_RATE     = 2'd2,
        REG_BRIGHTNESS    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][7:0] bytes;
        logic                      four_channels;
        logic                      frame_end;
    } load_t;

    typedef logic [1:0] chan_t;

    function automatic chan_t chan_order(input logic [3:0] code, input logic [1:0] slot);
        logic [7:0] row;
        begin
            case (code)
                4'd0:    row = {2'd3, 2'd2, 2'd1, 2'd0};
                4'd1:    row = {2'd3, 2'd1, 2'd2, 2'd0};
                4'd2:    row = {2'd3, 2'd2, 2'd0, 2'd1};
                4'd3:    row = {2'd3, 2'd0, 2'd2, 2'd1};
                4'd4:    row = {2'd3, 2'd1, 2'd0, 2'd2};
                4'd5:    row = {2'd3, 2'd0, 2'd1, 2'd2};
                4'd6:    row = {2'd2, 2'd1, 2'd0, 2'd3};
                4'd7:    row = {2'd3, 2'd2, 2'd1, 2'd0};
                4'd8:    row = {2'd1, 2'd2, 2'd0, 2'd3};
                4'd9:    row = {2'd1, 2'd2, 2'd3, 2'd0};
                4'd10:   row = {2'd2, 2'd0, 2'd3, 2'd1};
                4'd11:   row = {2'd2, 2'd3, 2'd0, 2'd1};
                4'd12:   row = {2'd0, 2'd3, 2'd2, 2'd1};
                4'd13:   row = {2'd0, 2'd2, 2'd3, 2'd1};
                4'd14:   row = {2'd1, 2'd0, 2'd3, 2'd2};
                4'd15:   row = {2'd1, 2'd3, 2'd0, 2'd2};
                default: row = {2'd3, 2'd2, 2'd1, 2'd0};
            endcase
            chan_order = row[slot*2 +: 2];
        end
    endfunction

endpackage

// File: rtl/core/ale_lane.sv
// One channel lane: pick the byte for this slot and apply the brightness scale.
// Depends on ale_pkg.
module ale_lane (
    input  logic [ale_pkg::NUM_LANES-1:0][7:0] pixel,
    input  ale_pkg::chan_t                     chan_sel,
    input  logic [7:0]                         brightness,
    output logic [7:0]                         value
);

    logic [7:0]  picked;
    logic [15:0] product;

    assign picked  = pixel[chan_sel];
    assign product = picked * brightness;
    assign value   = (brightness == ale_pkg::FULL_SCALE) ? picked : product[15:8];

endmodule

// File: rtl/core/ale_serializer.sv
// Merging stage: shifts lane bytes out MSB first as pulse results, latch if frame_end.
// Depends on ale_pkg.
module ale_serializer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            slow_rate,
    input  logic            load_valid,
    input  ale_pkg::load_t  load,
    output logic            load_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_high_len,
    output logic [13:0]     m_low_len,
    output logic            m_is_latch,
    output logic            m_last_of_item
);

    logic        active_reg, active_next;
    logic        latch_reg, latch_next;
    logic        end_reg, end_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] data_reg, data_next;
    logic        out_take;
    logic        finishing;

    assign out_take   = active_reg && m_ready;
    assign finishing  = out_take && (latch_reg || (cnt_reg == 5'd0 && !end_reg));
    assign load_ready = !active_reg || finishing;

    always_comb begin
        active_next = active_reg;
        latch_next  = latch_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        data_next   = data_reg;
        if (out_take) begin
            if (latch_reg) begin
                active_next = 1'b0;
            end else if (cnt_reg == 5'd0) begin
                if (end_reg) begin
                    latch_next = 1'b1;
                end else begin
                    active_next = 1'b0;
                end
            end else begin
                cnt_next  = cnt_reg - 5'd1;
                data_next = {data_reg[30:0], 1'b0};
            end
        end
        if (load_valid && load_ready) begin
            active_next = 1'b1;
            latch_next  = 1'b0;
            end_next    = load.frame_end;
            cnt_next    = load.four_channels ? ale_pkg::BITS_FOUR : ale_pkg::BITS_THREE;
            data_next   = {load.bytes[0], load.bytes[1], load.bytes[2], load.bytes[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            latch_reg  <= 1'b0;
            end_reg    <= 1'b0;
            cnt_reg    <= 5'd0;
        end else begin
            active_reg <= active_next;
            latch_reg  <= latch_next;
            end_reg    <= end_next;
            cnt_reg    <= cnt_next;
        end
        data_reg <= data_next;
    end

    always_comb begin
        if (latch_reg) begin
            m_high_len = 8'd0;
            m_low_len  = ale_pkg::LATCH_LEN;
        end else if (slow_rate) begin
            m_high_len = data_reg[31] ? ale_pkg::SLOW_HIGH_ONE : ale_pkg::SLOW_HIGH_ZERO;
            m_low_len  = ale_pkg::SLOW_LOW;
        end else begin
            m_high_len = data_reg[31] ? ale_pkg::FAST_HIGH_ONE : ale_pkg::FAST_HIGH_ZERO;
            m_low_len  = ale_pkg::FAST_LOW;
        end
    end

    assign m_valid        = active_reg;
    assign m_is_latch     = latch_reg;
    assign m_last_of_item = latch_reg || (cnt_reg == 5'd0 && !end_reg);

endmodule

// File: rtl/core/addressable_led_bit_encoder.sv
// Top level of the LED bit encoder: APB registers, four lanes, lane register, serializer.
// Depends on ale_pkg, ale_lane and ale_serializer.
//
//  channel  | direction | ports
//  ---------+-----------+-------------------------------------------------------
//  pixel    | in        | s_valid s_ready s_red s_green s_blue s_white s_frame_end
//  pulse    | out       | m_valid m_ready m_high_len m_low_len m_is_latch m_last_of_item
//  config   | in        | psel penable pwrite paddr pwdata prdata pready
//
// One pixel gives 24 or 32 pulse transactions plus one latch transaction when frame_end
// is set, one transaction per cycle from the serializer shift register unless stalled.
// The next pixel waits in the lane register, so the serializer runs without gaps.
// aresetn (synchronous) clears all control state and the registers to their defaults.
// A stall on m_ready holds the current transaction and backs up into s_ready.
module addressable_led_bit_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_white,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_high_len,
    output logic [13:0] m_low_len,
    output logic        m_is_latch,
    output logic        m_last_of_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] order_code_reg;
    logic       four_channels_reg;
    logic       slow_rate_reg;
    logic [7:0] brightness_reg;
    logic       cfg_write;
    ale_pkg::reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = ale_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_code_reg    <= 4'd0;
            four_channels_reg <= 1'b0;
            slow_rate_reg     <= 1'b0;
            brightness_reg    <= ale_pkg::FULL_SCALE;
        end else if (cfg_write) begin
            case (cfg_index)
                ale_pkg::REG_ORDER_CODE:    order_code_reg    <= pwdata[3:0];
                ale_pkg::REG_FOUR_CHANNELS: four_channels_reg <= pwdata[0];
                ale_pkg::REG_SLOW_RATE:     slow_rate_reg     <= pwdata[0];
                ale_pkg::REG_BRIGHTNESS:    brightness_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            ale_pkg::REG_ORDER_CODE:    prdata = {28'd0, order_code_reg};
            ale_pkg::REG_FOUR_CHANNELS: prdata = {31'd0, four_channels_reg};
            ale_pkg::REG_SLOW_RATE:     prdata = {31'd0, slow_rate_reg};
            ale_pkg::REG_BRIGHTNESS:    prdata = {24'd0, brightness_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    logic [ale_pkg::NUM_LANES-1:0][7:0] pixel;
    logic [ale_pkg::NUM_LANES-1:0][7:0] lane_value;

    assign pixel = {s_white, s_blue, s_green, s_red};

    for (genvar g = 0; g < ale_pkg::NUM_LANES; g++) begin : g_lane
        ale_lane u_lane (
            .pixel      (pixel),
            .chan_sel   (ale_pkg::chan_order(order_code_reg, 2'(g))),
            .brightness (brightness_reg),
            .value      (lane_value[g])
        );
    end

    logic           stage_valid_reg;
    ale_pkg::load_t stage_reg;
    logic           load_ready;

    assign s_ready = !stage_valid_reg || load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            stage_reg.bytes         <= lane_value;
            stage_reg.four_channels <= four_channels_reg;
            stage_reg.frame_end     <= s_frame_end;
        end
    end

    ale_serializer u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .slow_rate      (slow_rate_reg),
        .load_valid     (stage_valid_reg),
        .load           (stage_reg),
        .load_ready     (load_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_high_len     (m_high_len),
        .m_low_len      (m_low_len),
        .m_is_latch     (m_is_latch),
        .m_last_of_item (m_last_of_item)
    );

    a_latch_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_latch) |-> (m_last_of_item && m_high_len == 8'd0))
        else $error("latch transaction not marked last");

    a_no_double_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_latch) |=> !(m_valid && m_is_latch))
        else $error("two latch transactions in a row");

    a_no_gap_in_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_item) |=> m_valid)
        else $error("gap inside a pixel");

    a_stall_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready) || (m_valid && !m_last_of_item))
        else $error("input stalled while serializer could take the next pixel");

endmodule

// File: test/addressable_led_bit_encoder_test.sv
// Self-checking testbench for addressable_led_bit_encoder: pixel transactions in, bit pulses out.
// A built-in predictor forms the expected pulses; APB register writes are read back.
// Depends on ale_pkg and the addressable_led_bit_encoder RTL.
`timescale 1ns / 1ps

module addressable_led_bit_encoder_test;

    localparam logic [7:0]  T_FAST_ONE   = 8'd62;
    localparam logic [7:0]  T_FAST_ZERO  = 8'd28;
    localparam logic [13:0] T_FAST_LOW   = 14'd68;
    localparam logic [7:0]  T_SLOW_ONE   = 8'd125;
    localparam logic [7:0]  T_SLOW_ZERO  = 8'd55;
    localparam logic [13:0] T_SLOW_LOW   = 14'd150;
    localparam logic [13:0] T_LATCH_LOW  = 14'd7680;
    localparam int          DIR_ROWS     = 21;
    localparam int          PHASES       = 10;
    localparam int          PHASE_PIXELS = 50;
    localparam int          HOLD_CYCLES  = 600;

    typedef struct packed {
        logic [7:0]  high_len;
        logic [13:0] low_len;
        logic        is_latch;
        logic        last_of_item;
    } pulse_t;

    typedef struct packed {
        logic [3:0]  order;
        logic        four;
        logic        slow;
        logic [7:0]  bright;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
        logic        frame_end;
        logic        typed;
        logic [7:0]  typed_high;
        logic [13:0] typed_low;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_red;
    logic [7:0]  s_green;
    logic [7:0]  s_blue;
    logic [7:0]  s_white;
    logic        s_frame_end;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_high_len;
    logic [13:0] m_low_len;
    logic        m_is_latch;
    logic        m_last_of_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [3:0]  cfg_order  = 4'd0;
    logic        cfg_four   = 1'b0;
    logic        cfg_slow   = 1'b0;
    logic [7:0]  cfg_bright = 8'd255;

    logic        s_typed      = 1'b0;
    logic [7:0]  s_typed_high = 8'd0;
    logic [13:0] s_typed_low  = 14'd0;

    int          tx_pct = 0;
    int          rx_pct = 0;
    logic        hold_trig = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          err_count = 0;

    pulse_t      pending_pulses [$];
    stim_row_t   dir_table [DIR_ROWS];

    addressable_led_bit_encoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_white        (s_white),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_high_len     (m_high_len),
        .m_low_len      (m_low_len),
        .m_is_latch     (m_is_latch),
        .m_last_of_item (m_last_of_item),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [1:0] lane_of(input logic [3:0] code, input int slot);
        logic [7:0] row;
        case (code)
            4'd0:    row = {2'd0, 2'd1, 2'd2, 2'd3};
            4'd1:    row = {2'd0, 2'd2, 2'd1, 2'd3};
            4'd2:    row = {2'd1, 2'd0, 2'd2, 2'd3};
            4'd3:    row = {2'd1, 2'd2, 2'd0, 2'd3};
            4'd4:    row = {2'd2, 2'd0, 2'd1, 2'd3};
            4'd5:    row = {2'd2, 2'd1, 2'd0, 2'd3};
            4'd6:    row = {2'd3, 2'd0, 2'd1, 2'd2};
            4'd7:    row = {2'd0, 2'd1, 2'd2, 2'd3};
            4'd8:    row = {2'd3, 2'd0, 2'd2, 2'd1};
            4'd9:    row = {2'd0, 2'd3, 2'd2, 2'd1};
            4'd10:   row = {2'd1, 2'd3, 2'd0, 2'd2};
            4'd11:   row = {2'd1, 2'd0, 2'd3, 2'd2};
            4'd12:   row = {2'd1, 2'd2, 2'd3, 2'd0};
            4'd13:   row = {2'd1, 2'd3, 2'd2, 2'd0};
            4'd14:   row = {2'd2, 2'd3, 2'd0, 2'd1};
            default: row = {2'd2, 2'd0, 2'd3, 2'd1};
        endcase
        return row[(3 - slot) * 2 +: 2];
    endfunction

    function automatic void push_pulse(input logic [7:0] hi, input logic [13:0] lo,
                                       input logic latch, input logic last);
        pulse_t p;
        p.high_len     = hi;
        p.low_len      = lo;
        p.is_latch     = latch;
        p.last_of_item = last;
        pending_pulses.push_back(p);
    endfunction

    // Typed rows: every bit pulse carries the same high and low length.
    function automatic void expect_uniform(input logic [7:0] hi, input logic [13:0] lo,
                                           input logic fe);
        int nbits;
        nbits = cfg_four ? 32 : 24;
        for (int k = 0; k < nbits; k++)
            push_pulse(hi, lo, 1'b0, (k == nbits - 1) && !fe);
        if (fe)
            push_pulse(8'd0, T_LATCH_LOW, 1'b1, 1'b1);
    endfunction

    function automatic void predict_pixel_pulses(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] w,
                                                 input logic fe);
        logic [7:0]  lanes [4];
        logic [7:0]  v;
        logic [15:0] prod;
        logic [7:0]  hi1;
        logic [7:0]  hi0;
        logic [13:0] lo;
        int          nch;
        int          total;
        int          k;
        lanes[0] = r;
        lanes[1] = g;
        lanes[2] = b;
        lanes[3] = w;
        hi1   = cfg_slow ? T_SLOW_ONE : T_FAST_ONE;
        hi0   = cfg_slow ? T_SLOW_ZERO : T_FAST_ZERO;
        lo    = cfg_slow ? T_SLOW_LOW : T_FAST_LOW;
        nch   = cfg_four ? 4 : 3;
        total = nch * 8 + (fe ? 1 : 0);
        k     = 0;
        for (int c = 0; c < nch; c++) begin
            v = lanes[lane_of(cfg_order, c)];
            if (cfg_bright != 8'd255) begin
                prod = v * cfg_bright;
                v    = prod[15:8];
            end
            for (int i = 7; i >= 0; i--) begin
                push_pulse(v[i] ? hi1 : hi0, lo, 1'b0, k == total - 1);
                k++;
            end
        end
        if (fe)
            push_pulse(8'd0, T_LATCH_LOW, 1'b1, 1'b1);
    endfunction

    function automatic stim_row_t row(input logic [3:0] order, input logic four,
                                      input logic slow, input logic [7:0] bright,
                                      input logic [31:0] rgbw, input logic fe,
                                      input logic typed, input logic [7:0] th,
                                      input logic [13:0] tl);
        stim_row_t t;
        t.order      = order;
        t.four       = four;
        t.slow       = slow;
        t.bright     = bright;
        t.red        = rgbw[31:24];
        t.green      = rgbw[23:16];
        t.blue       = rgbw[15:8];
        t.white      = rgbw[7:0];
        t.frame_end  = fe;
        t.typed      = typed;
        t.typed_high = th;
        t.typed_low  = tl;
        return t;
    endfunction

    // Predict or check every transaction on both channels.
    always @(posedge aclk) begin
        pulse_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_typed)
                    expect_uniform(s_typed_high, s_typed_low, s_frame_end);
                else
                    predict_pixel_pulses(s_red, s_green, s_blue, s_white, s_frame_end);
            end
            if (m_valid && m_ready) begin
                if (pending_pulses.size() == 0) begin
                    report_mismatch("pulse with nothing expected, high_len", m_high_len, 0);
                end else begin
                    want = pending_pulses.pop_front();
                    if (m_high_len !== want.high_len)
                        report_mismatch("high_len", m_high_len, want.high_len);
                    if (m_low_len !== want.low_len)
                        report_mismatch("low_len", m_low_len, want.low_len);
                    if (m_is_latch !== want.is_latch)
                        report_mismatch("is_latch", m_is_latch, want.is_latch);
                    if (m_last_of_item !== want.last_of_item)
                        report_mismatch("last_of_item", m_last_of_item, want.last_of_item);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    task automatic drain(input int settle);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [3:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input ale_pkg::reg_index_t idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [3:0]  addr;
        case (idx)
            ale_pkg::REG_ORDER_CODE: mask = 32'h0000_000F;
            ale_pkg::REG_BRIGHTNESS: mask = 32'h0000_00FF;
            default:                 mask = 32'h0000_0001;
        endcase
        addr = {idx, 2'b00};
        // upper bits are random and must be dropped by the register
        apb_cycle(1'b1, addr, (val & mask) | ($urandom & ~mask));
        case (idx)
            ale_pkg::REG_ORDER_CODE:    cfg_order  = val[3:0];
            ale_pkg::REG_FOUR_CHANNELS: cfg_four   = val[0];
            ale_pkg::REG_SLOW_RATE:     cfg_slow   = val[0];
            default:                    cfg_bright = val[7:0];
        endcase
        apb_cycle(1'b0, addr, 32'd0);
        if (prdata !== (val & mask))
            report_mismatch("register readback", prdata, val & mask);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input logic [3:0] order, input logic four, input logic slow,
                                input logic [7:0] bright, input logic all_regs);
        if (all_regs || order != cfg_order || four != cfg_four || slow != cfg_slow
                || bright != cfg_bright) begin
            drain(8);
            if (all_regs || order != cfg_order)
                cfg_write(ale_pkg::REG_ORDER_CODE, {28'd0, order});
            if (all_regs || four != cfg_four)
                cfg_write(ale_pkg::REG_FOUR_CHANNELS, {31'd0, four});
            if (all_regs || slow != cfg_slow)
                cfg_write(ale_pkg::REG_SLOW_RATE, {31'd0, slow});
            if (all_regs || bright != cfg_bright)
                cfg_write(ale_pkg::REG_BRIGHTNESS, {24'd0, bright});
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] w, input logic fe, input logic typed,
                              input logic [7:0] th, input logic [13:0] tl);
        @(negedge aclk);
        while ($urandom_range(99) < tx_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_red        = r;
        s_green      = g;
        s_blue       = b;
        s_white      = w;
        s_frame_end  = fe;
        s_typed      = typed;
        s_typed_high = th;
        s_typed_low  = tl;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    initial begin
        logic [7:0] bright;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_red       = 8'd0;
        s_green     = 8'd0;
        s_blue      = 8'd0;
        s_white     = 8'd0;
        s_frame_end = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'd0;
        pwdata      = 32'd0;

        // first row runs on the reset values of all registers
        dir_table[0]  = row(0, 0, 0, 255, 32'h00000000, 0, 1, T_FAST_ZERO, T_FAST_LOW);
        dir_table[1]  = row(0, 0, 0, 255, 32'hFFFFFFFF, 1, 1, T_FAST_ONE, T_FAST_LOW);
        dir_table[2]  = row(0, 1, 0, 255, 32'hFFFFFFFF, 1, 1, T_FAST_ONE, T_FAST_LOW);
        dir_table[3]  = row(0, 1, 0, 0,   32'hFFFFFFFF, 0, 1, T_FAST_ZERO, T_FAST_LOW);
        dir_table[4]  = row(0, 1, 1, 255, 32'hFFFFFFFF, 1, 1, T_SLOW_ONE, T_SLOW_LOW);
        dir_table[5]  = row(0, 1, 1, 255, 32'h00000000, 0, 1, T_SLOW_ZERO, T_SLOW_LOW);
        dir_table[6]  = row(0, 0, 1, 0,   32'hA55A3CC3, 1, 1, T_SLOW_ZERO, T_SLOW_LOW);
        dir_table[7]  = row(0, 1, 0, 254, 32'hFFFFFFFF, 0, 0, 0, 0);
        dir_table[8]  = row(0, 1, 0, 1,   32'hFFFFFFFF, 0, 0, 0, 0);
        dir_table[9]  = row(0, 1, 0, 128, 32'h80817FFE, 0, 0, 0, 0);
        dir_table[10] = row(6, 0, 0, 255, 32'h000000FF, 1, 0, 0, 0);
        dir_table[11] = row(6, 1, 0, 255, 32'h12345678, 0, 0, 0, 0);
        dir_table[12] = row(12, 0, 0, 255, 32'h01020408, 0, 0, 0, 0);
        dir_table[13] = row(15, 1, 1, 255, 32'h80402010, 1, 0, 0, 0);
        dir_table[14] = row(7, 0, 0, 255, 32'hC0038118, 0, 0, 0, 0);
        dir_table[15] = row(8, 0, 0, 200, 32'h11223344, 0, 0, 0, 0);
        dir_table[16] = row(9, 1, 0, 255, 32'hAA55F00F, 0, 0, 0, 0);
        dir_table[17] = row(10, 0, 1, 255, 32'h0180FF00, 1, 0, 0, 0);
        dir_table[18] = row(13, 1, 0, 77, 32'hDEADBEEF, 0, 0, 0, 0);
        dir_table[19] = row(14, 0, 0, 255, 32'h7EE73CC3, 0, 0, 0, 0);
        dir_table[20] = row(3, 1, 0, 255, 32'h00FF00FF, 1, 0, 0, 0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            apply_config(dir_table[n].order, dir_table[n].four, dir_table[n].slow,
                         dir_table[n].bright, 1'b0);
            send_pixel(dir_table[n].red, dir_table[n].green, dir_table[n].blue,
                       dir_table[n].white, dir_table[n].frame_end, dir_table[n].typed,
                       dir_table[n].typed_high, dir_table[n].typed_low);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(4))
                0:       bright = 8'd0;
                1:       bright = 8'd255;
                2:       bright = 8'd254;
                3:       bright = 8'd1;
                default: bright = 8'($urandom_range(255));
            endcase
            apply_config(4'($urandom_range(15)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), bright, 1'b1);
            case (ph % 4)
                0:       begin tx_pct = 0;  rx_pct = 0;  end
                1:       begin tx_pct = 77; rx_pct = 0;  end
                2:       begin tx_pct = 0;  rx_pct = 77; end
                default: begin tx_pct = 19; rx_pct = 19; end
            endcase
            if (ph == 4) begin
                // hold the receiver while pixels keep coming until the input stalls
                @(negedge aclk);
                hold_trig = ~hold_trig;
            end
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           $urandom_range(3) == 0, 1'b0, 8'd0, 14'd0);
        end

        drain(40);
        if (err_count == 0 && pending_pulses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: addressable_led_bit_encoder.f
rtl/core/ale_pkg.sv
rtl/core/ale_lane.sv
rtl/core/ale_serializer.sv
rtl/core/addressable_led_bit_encoder.sv
test/addressable_led_bit_encoder_test.sv
